/* hw/rtl/lfs_pkg.sv */
// Package for the line-follow steering block.
// Holds field widths, register indexes, pattern codes and drive limits.
// No dependencies; every other file of the block imports it.
package lfs_pkg;

  localparam int SAMPLE_W  = 10;
  localparam int DRIVE_W   = 8;
  localparam int PATTERN_W = 4;
  localparam int ERROR_W   = 3;
  localparam int COUNT_W   = 16;
  localparam int GAIN_W    = 8;
  localparam int NUM_SENSORS = 4;

  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W  = 10;

  localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_0 = 3'd0;
  localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_1 = 3'd1;
  localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_2 = 3'd2;
  localparam logic [REG_INDEX_W-1:0] REG_THRESHOLD_3 = 3'd3;
  localparam logic [REG_INDEX_W-1:0] REG_GAIN        = 3'd4;
  localparam logic [REG_INDEX_W-1:0] REG_BASE_SPEED  = 3'd5;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 10'd512;

  localparam logic [PATTERN_W-1:0] PAT_CENTER     = 4'b0110;
  localparam logic [PATTERN_W-1:0] PAT_LEFT_1     = 4'b0100;
  localparam logic [PATTERN_W-1:0] PAT_LEFT_2     = 4'b1100;
  localparam logic [PATTERN_W-1:0] PAT_LEFT_3     = 4'b1000;
  localparam logic [PATTERN_W-1:0] PAT_RIGHT_1    = 4'b0010;
  localparam logic [PATTERN_W-1:0] PAT_RIGHT_2    = 4'b0011;
  localparam logic [PATTERN_W-1:0] PAT_RIGHT_3    = 4'b0001;
  localparam logic [PATTERN_W-1:0] PAT_ALL_ABOVE  = 4'b1111;

  localparam logic [DRIVE_W-1:0] DRIVE_MAX = 8'd255;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [DRIVE_W-1:0] drive_t;
  typedef logic signed [ERROR_W-1:0] error_t;

endpackage

/* hw/rtl/lfs_sensor_if.sv */
// Request channel carrying one set of four sensor samples.
// Depends on lfs_pkg for the sample width.
interface lfs_sensor_if import lfs_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample_0;
  sample_t sample_1;
  sample_t sample_2;
  sample_t sample_3;

  modport source (output valid, sample_0, sample_1, sample_2, sample_3, input ready);
  modport sink (input valid, sample_0, sample_1, sample_2, sample_3, output ready);
endinterface

/* hw/rtl/lfs_steer_if.sv */
// Request channel carrying one steering result.
// Depends on lfs_pkg for drive, pattern, error and count widths.
interface lfs_steer_if import lfs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  drive_t               left_drive;
  drive_t               right_drive;
  logic [PATTERN_W-1:0] sensor_pattern;
  error_t               steer_error;
  logic [COUNT_W-1:0]   crossing_count;

  modport source (output valid, left_drive, right_drive, sensor_pattern, steer_error,
                  crossing_count, input ready);
  modport sink (input valid, left_drive, right_drive, sensor_pattern, steer_error,
                crossing_count, output ready);
endinterface

/* hw/rtl/line_follow_steering.sv */
// Top level of the line-follow steering block.
// Depends on lfs_pkg, lfs_sensor_if and lfs_steer_if.
//
// Channel    Direction  Contents
// sensors    in         sample_0..sample_3, one request per sensor scan
// steering   out        left/right drive, sensor pattern, error, crossing count
// wr_*       in         register writes: thresholds, gain, base speed
//
// A request is decoded combinationally and its result registered, valid in the cycle after it is accepted.
// One request is accepted per cycle while the result register is empty or being drained.
// A stalled result holds the result register and blocks new requests until taken.
// Reset (synchronous, rst high) restores thresholds to 512, gain and base speed to 0,
// and clears the held error, crossing latch and crossing count.
module line_follow_steering import lfs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [REG_INDEX_W-1:0] wr_index,
  input  logic [REG_DATA_W-1:0]  wr_data,
  lfs_sensor_if.sink             sensors,
  lfs_steer_if.source            steering
);

  sample_t               threshold [NUM_SENSORS];
  logic [GAIN_W-1:0]     gain;
  drive_t                base_speed;

  error_t                last_error;
  logic                  crossing_latched;
  logic [COUNT_W-1:0]    crossings;

  logic                  out_valid;
  logic                  accept;

  sample_t               samples [NUM_SENSORS];
  logic [PATTERN_W-1:0]  pattern;
  logic                  any_below;
  error_t                error_next;
  logic signed [11:0]    prod;
  logic signed [11:0]    left_sum;
  logic signed [11:0]    right_sum;
  drive_t                left_next;
  drive_t                right_next;
  logic                  crossing_latched_next;
  logic [COUNT_W-1:0]    crossings_next;

  function automatic drive_t clamp_drive(input logic signed [11:0] v);
    drive_t r;
    if (v[11]) begin
      r = '0;
    end else if (v[10:8] != 3'd0) begin
      r = DRIVE_MAX;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  assign sensors.ready = !out_valid || steering.ready;
  assign accept = sensors.valid && sensors.ready;

  assign samples[0] = sensors.sample_0;
  assign samples[1] = sensors.sample_1;
  assign samples[2] = sensors.sample_2;
  assign samples[3] = sensors.sample_3;

  always_comb begin
    any_below = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      pattern[NUM_SENSORS-1-i] = samples[i] > threshold[i];
      if (samples[i] < threshold[i]) begin
        any_below = 1'b1;
      end
    end
  end

  always_comb begin
    unique case (pattern)
      PAT_CENTER:  error_next = 3'sd0;
      PAT_LEFT_1:  error_next = -3'sd1;
      PAT_LEFT_2:  error_next = -3'sd2;
      PAT_LEFT_3:  error_next = -3'sd3;
      PAT_RIGHT_1: error_next = 3'sd1;
      PAT_RIGHT_2: error_next = 3'sd2;
      PAT_RIGHT_3: error_next = 3'sd3;
      default:     error_next = last_error;
    endcase
  end

  assign prod = signed'({4'b0000, gain}) * signed'({{9{error_next[2]}}, error_next});
  assign left_sum = signed'({4'b0000, base_speed}) + prod;
  assign right_sum = signed'({4'b0000, base_speed}) - prod;
  assign left_next = clamp_drive(left_sum);
  assign right_next = clamp_drive(right_sum);

  always_comb begin
    crossing_latched_next = crossing_latched;
    crossings_next = crossings;
    if (pattern == PAT_ALL_ABOVE && !crossing_latched) begin
      crossings_next = crossings + 16'd1;
      crossing_latched_next = 1'b1;
    end else if (any_below) begin
      crossing_latched_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++) begin
        threshold[i] <= THRESHOLD_RESET;
      end
      gain <= '0;
      base_speed <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_THRESHOLD_0: threshold[0] <= wr_data;
        REG_THRESHOLD_1: threshold[1] <= wr_data;
        REG_THRESHOLD_2: threshold[2] <= wr_data;
        REG_THRESHOLD_3: threshold[3] <= wr_data;
        REG_GAIN:        gain <= wr_data[GAIN_W-1:0];
        REG_BASE_SPEED:  base_speed <= wr_data[DRIVE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_error <= '0;
      crossing_latched <= 1'b0;
      crossings <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        last_error <= error_next;
        crossing_latched <= crossing_latched_next;
        crossings <= crossings_next;
        out_valid <= 1'b1;
      end else if (steering.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      steering.left_drive <= left_next;
      steering.right_drive <= right_next;
      steering.sensor_pattern <= pattern;
      steering.steer_error <= error_next;
      steering.crossing_count <= crossings_next;
    end
  end

  assign steering.valid = out_valid;

endmodule

/* sim/line_follow_steering_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for line_follow_steering: random and directed sensor scans,
// register writes between phases, and a steering predictor. Needs lfs_pkg and both interfaces.
module line_follow_steering_tb import lfs_pkg::*; ();

  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 200;
  localparam int PHASES         = 9;
  localparam int PHASE_SCANS    = 200;

  localparam logic [REG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [REG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [PATTERN_W-1:0] TRACK_PATTERNS [7] = '{
    PAT_CENTER, PAT_LEFT_1, PAT_LEFT_2, PAT_LEFT_3, PAT_RIGHT_1, PAT_RIGHT_2, PAT_RIGHT_3
  };

  typedef enum logic [1:0] {STEP_SCAN, STEP_WRITE, STEP_DRAIN} step_kind_e;

  typedef struct {
    step_kind_e                kind;
    sample_t [NUM_SENSORS-1:0] smp;
    logic [REG_INDEX_W-1:0]    index;
    logic [REG_DATA_W-1:0]     data;
    bit                        bursty;
  } stim_t;

  typedef struct packed {
    drive_t               left;
    drive_t               right;
    logic [PATTERN_W-1:0] pattern;
    error_t               error;
    logic [COUNT_W-1:0]   count;
  } steer_res_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [REG_INDEX_W-1:0] wr_index;
  logic [REG_DATA_W-1:0]  wr_data;

  lfs_sensor_if sensors ();
  lfs_steer_if  steering ();

  line_follow_steering dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .sensors  (sensors),
    .steering (steering)
  );

  stim_t      scan_plan[$];
  steer_res_t expected_steering[$];
  sample_t    plan_level [NUM_SENSORS];

  sample_t            level [NUM_SENSORS];
  logic [GAIN_W-1:0]  prop_gain;
  drive_t             cruise_speed;
  error_t             held_error;
  logic               cross_seen;
  logic [COUNT_W-1:0] crossing_total;

  bit bursty;
  int send_gap;
  int settle;
  int stall;
  int stuck;
  int failures;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_scan(sample_t [NUM_SENSORS-1:0] smp);
    stim_t st;
    st = '{kind: STEP_SCAN, smp: smp, index: '0, data: '0, bursty: 1'b0};
    scan_plan.push_back(st);
  endfunction

  function automatic void add_write(logic [REG_INDEX_W-1:0] index, int data);
    stim_t st;
    st = '{kind: STEP_WRITE, smp: '0, index: index, data: REG_DATA_W'(data), bursty: 1'b0};
    if (index <= REG_THRESHOLD_3)
      plan_level[index[1:0]] = sample_t'(data);
    scan_plan.push_back(st);
  endfunction

  function automatic void add_drain(bit bursty_after);
    stim_t st;
    st = '{kind: STEP_DRAIN, smp: '0, index: '0, data: '0, bursty: bursty_after};
    scan_plan.push_back(st);
  endfunction

  function automatic sample_t pick_sample(sample_t lvl, bit want_above);
    if (want_above)
      return (lvl == SAMPLE_MAX) ? lvl : sample_t'($urandom_range(int'(lvl) + 1, SAMPLE_MAX));
    if (lvl == 0 || $urandom_range(0, 4) == 0)
      return lvl;
    return sample_t'($urandom_range(0, int'(lvl) - 1));
  endfunction

  function automatic void add_pattern_scan(logic [PATTERN_W-1:0] pat);
    sample_t [NUM_SENSORS-1:0] smp;
    for (int i = 0; i < NUM_SENSORS; i++)
      smp[i] = pick_sample(plan_level[i], pat[NUM_SENSORS-1-i]);
    add_scan(smp);
  endfunction

  function automatic void add_random_scan();
    int                        pick;
    sample_t [NUM_SENSORS-1:0] smp;
    pick = $urandom_range(0, 9);
    if (pick >= 8) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        smp[i] = sample_t'($urandom_range(0, SAMPLE_MAX));
      add_scan(smp);
    end else if (pick <= 5) begin
      add_pattern_scan(TRACK_PATTERNS[$urandom_range(0, 6)]);
    end else if (pick == 6) begin
      add_pattern_scan(PAT_ALL_ABOVE);
    end else begin
      add_pattern_scan(PATTERN_W'($urandom_range(0, 15)));
    end
  endfunction

  function automatic int padded(int value);
    int data;
    data = $urandom_range(0, (1 << REG_DATA_W) - 1);
    data[7:0] = value[7:0];
    return data;
  endfunction

  function automatic logic [REG_INDEX_W-1:0] threshold_index(int i);
    return REG_INDEX_W'(int'(REG_THRESHOLD_0) + i);
  endfunction

  function automatic steer_res_t predict_steering(sample_t [NUM_SENSORS-1:0] smp);
    steer_res_t           res;
    logic [PATTERN_W-1:0] pat;
    logic                 any_below;
    error_t               err;
    int                   prod;
    int                   left;
    int                   right;
    pat = '0;
    any_below = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (smp[i] > level[i])
        pat[NUM_SENSORS-1-i] = 1'b1;
      if (smp[i] < level[i])
        any_below = 1'b1;
    end
    case (pat)
      PAT_CENTER:  err = error_t'(0);
      PAT_LEFT_1:  err = error_t'(-1);
      PAT_LEFT_2:  err = error_t'(-2);
      PAT_LEFT_3:  err = error_t'(-3);
      PAT_RIGHT_1: err = error_t'(1);
      PAT_RIGHT_2: err = error_t'(2);
      PAT_RIGHT_3: err = error_t'(3);
      default:     err = held_error;
    endcase
    held_error = err;
    prod = int'(prop_gain) * int'(err);
    left = int'(cruise_speed) + prod;
    right = int'(cruise_speed) - prod;
    if (left < 0) left = 0;
    if (left > int'(DRIVE_MAX)) left = int'(DRIVE_MAX);
    if (right < 0) right = 0;
    if (right > int'(DRIVE_MAX)) right = int'(DRIVE_MAX);
    if (pat == PAT_ALL_ABOVE && !cross_seen) begin
      crossing_total = crossing_total + 1'b1;
      cross_seen = 1'b1;
    end else if (any_below) begin
      cross_seen = 1'b0;
    end
    res.left = drive_t'(left);
    res.right = drive_t'(right);
    res.pattern = pat;
    res.error = err;
    res.count = crossing_total;
    return res;
  endfunction

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  // Driver: feeds requests and register writes from the plan.
  always @(posedge clk) begin
    stim_t head;
    logic  nxt_valid;
    logic  nxt_wr;
    if (rst) begin
      sensors.valid <= 1'b0;
      sensors.sample_0 <= '0;
      sensors.sample_1 <= '0;
      sensors.sample_2 <= '0;
      sensors.sample_3 <= '0;
      wr_en <= 1'b0;
      wr_index <= '0;
      wr_data <= '0;
      bursty <= 1'b1;
      send_gap = 0;
      settle = 0;
    end else begin
      nxt_valid = sensors.valid && !sensors.ready;
      nxt_wr = 1'b0;
      if (sensors.valid && sensors.ready && bursty && $urandom_range(0, 3) == 0)
        send_gap = $urandom_range(1, 7);
      if (!nxt_valid && scan_plan.size() > 0) begin
        head = scan_plan[0];
        if (send_gap > 0) begin
          send_gap--;
        end else begin
          case (head.kind)
            STEP_SCAN: begin
              sensors.sample_0 <= head.smp[0];
              sensors.sample_1 <= head.smp[1];
              sensors.sample_2 <= head.smp[2];
              sensors.sample_3 <= head.smp[3];
              nxt_valid = 1'b1;
              void'(scan_plan.pop_front());
            end
            STEP_WRITE: begin
              wr_index <= head.index;
              wr_data <= head.data;
              nxt_wr = 1'b1;
              void'(scan_plan.pop_front());
            end
            default: begin
              if (expected_steering.size() == 0 && !steering.valid && !sensors.valid)
                settle++;
              else
                settle = 0;
              if (settle == SETTLE_CYCLES) begin
                settle = 0;
                bursty <= head.bursty;
                void'(scan_plan.pop_front());
              end
            end
          endcase
        end
      end
      sensors.valid <= nxt_valid;
      wr_en <= nxt_wr;
    end
  end

  // Monitor: tracks register writes, predicts each request, checks each result.
  always @(posedge clk) begin
    steer_res_t want;
    if (rst) begin
      for (int i = 0; i < NUM_SENSORS; i++)
        level[i] = THRESHOLD_RESET;
      prop_gain = '0;
      cruise_speed = '0;
      held_error = '0;
      cross_seen = 1'b0;
      crossing_total = '0;
      stall = 0;
      steering.ready <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_THRESHOLD_0, REG_THRESHOLD_1, REG_THRESHOLD_2, REG_THRESHOLD_3:
            level[wr_index[1:0]] = wr_data;
          REG_GAIN:       prop_gain = wr_data[GAIN_W-1:0];
          REG_BASE_SPEED: cruise_speed = wr_data[DRIVE_W-1:0];
          default: ;
        endcase
      end
      if (sensors.valid && sensors.ready)
        expected_steering.push_back(predict_steering(
          {sensors.sample_3, sensors.sample_2, sensors.sample_1, sensors.sample_0}));
      if (steering.valid && steering.ready) begin
        if (expected_steering.size() == 0) begin
          $error("steering result with no request outstanding");
          failures++;
        end else begin
          want = expected_steering.pop_front();
          compare_field("left_drive", int'(want.left), int'(steering.left_drive));
          compare_field("right_drive", int'(want.right), int'(steering.right_drive));
          compare_field("sensor_pattern", int'(want.pattern), int'(steering.sensor_pattern));
          compare_field("steer_error", int'(want.error), int'(steering.steer_error));
          compare_field("crossing_count", int'(want.count), int'(steering.crossing_count));
        end
      end
      if (stall > 0) begin
        stall--;
        steering.ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 6);
        steering.ready <= 1'b0;
      end else begin
        steering.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || wr_en || (sensors.valid && sensors.ready) ||
        (steering.valid && steering.ready)) begin
      stuck = 0;
    end else if (stuck == WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck++;
    end
  end

  initial begin
    bit phase_bursty;
    rst = 1'b1;
    for (int i = 0; i < NUM_SENSORS; i++)
      plan_level[i] = THRESHOLD_RESET;

    // Reset settings: equal samples neither set a bit nor re-arm the crossing latch.
    add_scan({4{sample_t'(0)}});
    add_scan({4{sample_t'(SAMPLE_MAX)}});
    add_scan({4{THRESHOLD_RESET}});
    add_scan({4{sample_t'(SAMPLE_MAX)}});
    add_scan({sample_t'(511), sample_t'(513), sample_t'(513), sample_t'(511)});

    add_drain(1'b1);
    add_write(REG_SPARE_6, 'h3FF);
    add_write(REG_SPARE_7, 'h155);
    add_write(REG_GAIN, padded(50));
    add_write(REG_BASE_SPEED, padded(128));
    for (int i = 0; i < 7; i++)
      add_pattern_scan(TRACK_PATTERNS[i]);
    add_pattern_scan(4'b0101);
    add_pattern_scan(4'b0000);
    add_pattern_scan(PAT_ALL_ABOVE);
    add_pattern_scan(PAT_ALL_ABOVE);
    add_scan({4{THRESHOLD_RESET}});
    add_pattern_scan(PAT_ALL_ABOVE);
    add_scan({4{sample_t'(0)}});
    add_pattern_scan(PAT_ALL_ABOVE);

    for (int p = 0; p < PHASES; p++) begin
      phase_bursty = !(p == 4 || p == PHASES - 1);
      add_drain(phase_bursty);
      case (p)
        1: begin
          for (int i = 0; i < NUM_SENSORS; i++)
            add_write(threshold_index(i), 0);
          add_write(REG_GAIN, padded(255));
          add_write(REG_BASE_SPEED, padded(255));
        end
        2: begin
          for (int i = 0; i < NUM_SENSORS; i++)
            add_write(threshold_index(i), SAMPLE_MAX);
          add_write(REG_GAIN, padded(255));
          add_write(REG_BASE_SPEED, padded(0));
        end
        3: begin
          for (int i = 0; i < NUM_SENSORS; i++)
            add_write(threshold_index(i), (i % 2 == 0) ? 0 : SAMPLE_MAX);
          add_write(REG_GAIN, padded(0));
          add_write(REG_BASE_SPEED, padded(255));
        end
        default: begin
          for (int i = 0; i < NUM_SENSORS; i++)
            add_write(threshold_index(i), ($urandom_range(0, 3) == 0) ?
                      $urandom_range(0, SAMPLE_MAX) : $urandom_range(100, 900));
          add_write(REG_GAIN, padded(($urandom_range(0, 3) == 0) ?
                    $urandom_range(0, 255) : $urandom_range(0, 40)));
          add_write(REG_BASE_SPEED, padded($urandom_range(0, 255)));
        end
      endcase
      for (int n = 0; n < PHASE_SCANS; n++) begin
        if (n == PHASE_SCANS / 2)
          add_drain(phase_bursty);
        add_random_scan();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (scan_plan.size() != 0 || sensors.valid)
      @(posedge clk);
    while (expected_steering.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (failures == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
